### hw/rtl/assert_macros.svh
// Assertion macros shared by the multiply/divide and work RAM port RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on the rising clock edge.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
// Next-cycle implication, checked on the rising clock edge.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/mdw_pkg.sv
// Package for the multiply/divide and work RAM port: sizes, register map,
// sequencer states and the request/response structs of the math unit.
// No dependencies.
package mdw_pkg;

    localparam int WRAM_ADDR_BITS = 17;
    localparam int WRAM_DEPTH     = 1 << WRAM_ADDR_BITS;
    localparam int PTR_IMG_BITS   = 24;

    typedef logic [7:0]                t_byte;
    typedef logic [15:0]               t_addr16;
    typedef logic [15:0]               t_word;
    typedef logic [WRAM_ADDR_BITS-1:0] t_wram_addr;

    // Register map
    localparam t_addr16 ADDR_WRAM_DATA = 16'h2180;
    localparam t_addr16 ADDR_PTR_LO    = 16'h2181;
    localparam t_addr16 ADDR_PTR_MID   = 16'h2182;
    localparam t_addr16 ADDR_PTR_HI    = 16'h2183;
    localparam t_addr16 ADDR_FACTOR_A  = 16'h4202;
    localparam t_addr16 ADDR_FACTOR_B  = 16'h4203;
    localparam t_addr16 ADDR_DIVD_LO   = 16'h4204;
    localparam t_addr16 ADDR_DIVD_HI   = 16'h4205;
    localparam t_addr16 ADDR_DIVISOR   = 16'h4206;
    localparam t_addr16 ADDR_QUOT_LO   = 16'h4214;
    localparam t_addr16 ADDR_QUOT_HI   = 16'h4215;
    localparam t_addr16 ADDR_PRDREM_LO = 16'h4216;
    localparam t_addr16 ADDR_PRDREM_HI = 16'h4217;

    localparam t_word DIV_ZERO_QUOT = 16'hFFFF;

    // Access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Math unit step counts
    localparam int MUL_STEPS = 8;
    localparam int DIV_STEPS = 16;
    localparam int CNT_BITS  = $clog2(DIV_STEPS);
    localparam int ALU_BITS  = 10;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RAM_RD,
        ST_MATH,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic  start;
        logic  is_div;
        t_byte opnd;    // multiplicand or divisor
        t_word value;   // multiplier (low byte) or dividend
    } t_math_req;

    typedef struct packed {
        logic  done;
        logic  is_div;
        t_word quotient;
        t_word prod_rem;
    } t_math_rsp;

endpackage

### hw/rtl/mdw_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module mdw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/mdw_math.sv
// Iterative 8x8 multiply (shift-add) and 16-by-8 restoring divide that
// share one 10-bit adder/subtractor. Depends on mdw_pkg, assert_macros.svh.
`include "assert_macros.svh"

module mdw_math (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mdw_pkg::t_math_req i_req,
    output mdw_pkg::t_math_rsp o_rsp
);
    import mdw_pkg::*;

    localparam logic [CNT_BITS-1:0] MUL_LAST = CNT_BITS'(MUL_STEPS - 1);
    localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(DIV_STEPS - 1);

    logic                r_run, n_run;
    logic                r_done, n_done;
    logic                r_is_div, n_is_div;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    t_byte               r_hi, n_hi;
    t_word               r_lo, n_lo;
    t_byte               r_opnd, n_opnd;

    logic [ALU_BITS-1:0] w_x, w_y, w_sum;
    logic                w_sub;
    logic                w_last;
    logic                w_ge;

    // Shared adder/subtractor
    always_comb begin
        if (r_is_div) begin
            w_x   = {1'b0, r_hi, r_lo[15]};
            w_y   = {2'b00, r_opnd};
            w_sub = 1'b1;
        end else begin
            w_x   = {2'b00, r_hi};
            w_y   = r_lo[0] ? {2'b00, r_opnd} : '0;
            w_sub = 1'b0;
        end
        w_sum = w_x + (w_sub ? ~w_y : w_y) + ALU_BITS'(w_sub);
    end

    assign w_ge   = ~w_sum[ALU_BITS-1];
    assign w_last = (r_cnt == (r_is_div ? DIV_LAST : MUL_LAST));

    always_comb begin
        n_run    = r_run;
        n_done   = 1'b0;
        n_is_div = r_is_div;
        n_cnt    = r_cnt;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_opnd   = r_opnd;
        if (i_req.start) begin
            n_run    = 1'b1;
            n_is_div = i_req.is_div;
            n_cnt    = '0;
            n_hi     = '0;
            n_lo     = i_req.value;
            n_opnd   = i_req.opnd;
        end else if (r_run) begin
            if (r_is_div) begin
                n_hi = w_ge ? w_sum[7:0] : w_x[7:0];
                n_lo = {r_lo[14:0], w_ge};
            end else begin
                n_hi = w_sum[8:1];
                n_lo = {r_lo[15:8], w_sum[0], r_lo[7:1]};
            end
            n_cnt = r_cnt + CNT_BITS'(1);
            if (w_last) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_is_div <= n_is_div;
        r_cnt    <= n_cnt;
        r_hi     <= n_hi;
        r_lo     <= n_lo;
        r_opnd   <= n_opnd;
    end

    always_comb begin
        o_rsp.done     = r_done;
        o_rsp.is_div   = r_is_div;
        o_rsp.quotient = r_lo;
        o_rsp.prod_rem = r_is_div ? {8'h00, r_hi} : {r_hi, r_lo[7:0]};
    end

    `ASSERT_IMP(a_start_when_free, i_clk, i_rst_n, i_req.start, !r_run && !r_done)
    `ASSERT_NXT(a_done_single, i_clk, i_rst_n, r_done, !r_done)
    `ASSERT_IMP(a_mul_hi_clear, i_clk, i_rst_n, r_run && !r_is_div, r_lo[15:8] == 8'h00)

endmodule

### hw/rtl/multiply_divide_and_wram_port.sv
// Top level of the multiply/divide unit and work RAM data port.
// Depends on mdw_pkg, mdw_ram, mdw_math and assert_macros.svh.
//
// One bus access is taken per transfer: start high while busy is low
// transfers i_cmd, i_bus_address and i_write_byte. Every access gives exactly
// one result: o_strobe is high for one cycle with o_read_byte, and the
// receiver must take it then, since the block cannot hold it. After reset the
// block sweeps the 2^WRAM_ADDR_BITS byte work RAM to zero, one byte per
// cycle, and keeps busy high until done.
// Path from the transfer to the strobe, by kind of access:
//   register access, unmapped address, work RAM write : straight to ST_RESP
//   work RAM read (registered RAM read port)          : ST_RAM_RD, then ST_RESP
//   write to 0x4203, 8x8 multiply                     : ST_MATH until done, then ST_RESP
//   write to 0x4206, 16-by-8 divide, nonzero divisor  : ST_MATH until done, then ST_RESP
// The multiply and divide run one bit per cycle through one shared
// adder/subtractor; the 16 quotient bits of a divide set the worst case.
// Busy drops in the cycle after the strobe.
// A divide by zero finishes at once: quotient 0xFFFF, remainder = dividend.
`include "assert_macros.svh"

module multiply_divide_and_wram_port (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic            i_cmd,
    input  mdw_pkg::t_addr16 i_bus_address,
    input  mdw_pkg::t_byte   i_write_byte,
    output logic            o_strobe,
    output mdw_pkg::t_byte   o_read_byte
);
    import mdw_pkg::*;

    t_state     r_state, n_state;
    t_wram_addr r_clr_addr, n_clr_addr;
    t_wram_addr r_ptr, n_ptr;
    t_byte      r_factor_a, n_factor_a;
    t_word      r_dividend, n_dividend;
    t_word      r_quotient, n_quotient;
    t_word      r_prod_rem, n_prod_rem;
    t_byte      r_result, n_result;

    logic       w_accept;
    logic       w_is_data;
    logic       w_math_go;
    logic       w_ram_we;
    t_wram_addr w_ram_addr;
    t_byte      w_ram_wdata;
    t_byte      w_ram_rdata;
    logic [PTR_IMG_BITS-1:0] w_ptr_img;

    t_math_req  w_math_req;
    t_math_rsp  w_math_rsp;

    assign w_accept  = start && (r_state == ST_IDLE);
    assign w_is_data = (i_bus_address == ADDR_WRAM_DATA);
    // Start the shared unit for a multiply, or a divide with a nonzero divisor
    assign w_math_go = (i_cmd == CMD_WRITE) &&
                       ((i_bus_address == ADDR_FACTOR_B) ||
                        ((i_bus_address == ADDR_DIVISOR) && (i_write_byte != 8'h00)));

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    if ((i_cmd == CMD_READ) && w_is_data) begin
                        n_state = ST_RAM_RD;
                    end else if (w_math_go) begin
                        n_state = ST_MATH;
                    end else begin
                        n_state = ST_RESP;
                    end
                end
            end
            ST_RAM_RD: n_state = ST_RESP;
            ST_MATH: begin
                if (w_math_rsp.done) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Outputs of the sequencer
    // ---------------------------------------------------------------
    always_comb begin
        busy        = 1'b1;
        o_strobe    = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_addr  = r_ptr;
        w_ram_wdata = i_write_byte;
        case (r_state)
            ST_CLEAR: begin
                // Sweep zeros through the RAM
                w_ram_we    = 1'b1;
                w_ram_addr  = r_clr_addr;
                w_ram_wdata = '0;
            end
            ST_IDLE: begin
                busy     = 1'b0;
                w_ram_we = start && (i_cmd == CMD_WRITE) && w_is_data;
            end
            ST_RESP:  o_strobe = 1'b1;
            default: ;
        endcase
    end

    assign o_read_byte = r_result;

    always_comb begin
        w_math_req.start  = w_accept && w_math_go;
        w_math_req.is_div = (i_bus_address == ADDR_DIVISOR);
        w_math_req.opnd   = (i_bus_address == ADDR_DIVISOR) ? i_write_byte : r_factor_a;
        w_math_req.value  = (i_bus_address == ADDR_DIVISOR) ? r_dividend
                                                             : {8'h00, i_write_byte};
    end

    // ---------------------------------------------------------------
    // Register file, pointer and read data
    // ---------------------------------------------------------------
    assign w_ptr_img = PTR_IMG_BITS'(r_ptr);

    always_comb begin
        n_clr_addr = r_clr_addr;
        n_ptr      = r_ptr;
        n_factor_a = r_factor_a;
        n_dividend = r_dividend;
        n_quotient = r_quotient;
        n_prod_rem = r_prod_rem;
        n_result   = r_result;

        if (r_state == ST_CLEAR) begin
            n_clr_addr = r_clr_addr + WRAM_ADDR_BITS'(1);
        end

        if (w_accept) begin
            n_result = '0;
            if (w_is_data) begin
                // Advance and wrap on both reads and writes
                n_ptr = r_ptr + WRAM_ADDR_BITS'(1);
            end
            if (i_cmd == CMD_WRITE) begin
                case (i_bus_address)
                    ADDR_PTR_LO: n_ptr = WRAM_ADDR_BITS'({w_ptr_img[23:8], i_write_byte});
                    ADDR_PTR_MID: n_ptr = WRAM_ADDR_BITS'({w_ptr_img[23:16], i_write_byte,
                                                           w_ptr_img[7:0]});
                    ADDR_PTR_HI: n_ptr = WRAM_ADDR_BITS'({i_write_byte, w_ptr_img[15:0]});
                    ADDR_FACTOR_A: n_factor_a = i_write_byte;
                    ADDR_DIVD_LO: n_dividend = {r_dividend[15:8], i_write_byte};
                    ADDR_DIVD_HI: n_dividend = {i_write_byte, r_dividend[7:0]};
                    ADDR_DIVISOR: begin
                        if (i_write_byte == 8'h00) begin
                            n_quotient = DIV_ZERO_QUOT;
                            n_prod_rem = r_dividend;
                        end
                    end
                    default: ;
                endcase
            end else begin
                case (i_bus_address)
                    ADDR_QUOT_LO:   n_result = r_quotient[7:0];
                    ADDR_QUOT_HI:   n_result = r_quotient[15:8];
                    ADDR_PRDREM_LO: n_result = r_prod_rem[7:0];
                    ADDR_PRDREM_HI: n_result = r_prod_rem[15:8];
                    default: ;
                endcase
            end
        end

        if (r_state == ST_RAM_RD) begin
            n_result = w_ram_rdata;
        end

        // Drop the math results in when the shared unit finishes
        if ((r_state == ST_MATH) && w_math_rsp.done) begin
            n_prod_rem = w_math_rsp.prod_rem;
            if (w_math_rsp.is_div) begin
                n_quotient = w_math_rsp.quotient;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_ptr      <= '0;
            r_factor_a <= '0;
            r_dividend <= '0;
            r_quotient <= '0;
            r_prod_rem <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_ptr      <= n_ptr;
            r_factor_a <= n_factor_a;
            r_dividend <= n_dividend;
            r_quotient <= n_quotient;
            r_prod_rem <= n_prod_rem;
        end
        r_result <= n_result;
    end

    mdw_ram #(
        .WIDTH(8),
        .DEPTH(WRAM_DEPTH)
    ) u_wram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    mdw_math u_math (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_math_req),
        .o_rsp   (w_math_rsp)
    );

    `ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, w_accept, busy)
    `ASSERT_IMP(a_clear_quiet, i_clk, i_rst_n, r_state == ST_CLEAR, !o_strobe && busy)
    `ASSERT_NXT(a_ptr_advance, i_clk, i_rst_n, w_accept && w_is_data, r_ptr == $past(r_ptr) + WRAM_ADDR_BITS'(1))
    `ASSERT_IMP(a_done_in_math, i_clk, i_rst_n, w_math_rsp.done, r_state == ST_MATH)

endmodule

### test/multiply_divide_and_wram_port_test.sv
// Self-checking testbench for multiply_divide_and_wram_port: bus accesses go in through the
// start/busy handshake and each returned read byte is checked against an in-bench predictor.
// Depends on mdw_pkg and the multiply_divide_and_wram_port RTL.
module multiply_divide_and_wram_port_test;

    import mdw_pkg::*;

    // Reset sweep of the work RAM plus generous margin; anything slower is a hang.
    localparam int      WATCHDOG_LIMIT = 4 * WRAM_DEPTH + 2000;
    // The longest access is a divide; let a little more go by before the verdict.
    localparam int      TAIL_CYCLES    = 40;
    localparam int      RANDOM_ITEMS   = 1600;
    localparam t_addr16 ADDR_UNMAPPED  = 16'hFFFF;

    typedef struct {
        logic        cmd;
        t_addr16     addr;
        t_byte       data;
        int unsigned gap;          // idle cycles before this access is offered
        bit          drain_first;  // hold this access until nothing is outstanding
    } t_bus_access;

    logic    i_clk;
    logic    i_rst_n       = 1'b0;
    logic    start         = 1'b0;
    logic    busy;
    logic    i_cmd         = CMD_READ;
    t_addr16 i_bus_address = '0;
    t_byte   i_write_byte  = '0;
    logic    o_strobe;
    t_byte   o_read_byte;

    t_bus_access access_q[$];
    t_byte       read_bytes_due[$];
    int          fail_count  = 0;
    int          idle_cycles = 0;
    int unsigned wait_left   = 0;

    // Predictor state: shadow copies of the RAM, pointer and math registers.
    t_byte      wram_image [int];
    t_wram_addr wram_ptr = '0;
    t_byte      fac_a    = '0;
    t_byte      fac_b    = '0;
    t_word      dividend = '0;
    t_byte      divisor  = '0;
    t_word      quotient = '0;
    t_word      prod_rem = '0;

    multiply_divide_and_wram_port DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_bus_address (i_bus_address),
        .i_write_byte  (i_write_byte),
        .o_strobe      (o_strobe),
        .o_read_byte   (o_read_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Queue one access. Gaps come in stretches: every fourth block of 64 accesses
    // runs with no idling at all. Every 400th access waits for the pipe to drain.
    task automatic push_access(input logic cmd, input t_addr16 addr, input t_byte data);
        t_bus_access acc;
        acc.cmd         = cmd;
        acc.addr        = addr;
        acc.data        = data;
        acc.gap         = ((access_q.size() / 64) % 4 == 0) ? 0 : $urandom_range(0, 10);
        acc.drain_first = (access_q.size() != 0) && (access_q.size() % 400 == 0);
        access_q.push_back(acc);
    endtask

    // Apply one transferred access to the shadow state and queue the byte it returns.
    task automatic predict_access(input t_bus_access acc);
        t_byte       rd;
        logic [31:0] ptr_wide;
        rd       = '0;
        ptr_wide = 32'(wram_ptr);
        if (acc.cmd == CMD_WRITE) begin
            case (acc.addr)
                ADDR_WRAM_DATA: begin
                    wram_image[int'(wram_ptr)] = acc.data;
                    wram_ptr = wram_ptr + 1'b1;
                end
                ADDR_PTR_LO:
                    wram_ptr = t_wram_addr'((ptr_wide & ~32'h0000_00FF) | 32'(acc.data));
                ADDR_PTR_MID:
                    wram_ptr = t_wram_addr'((ptr_wide & ~32'h0000_FF00) | (32'(acc.data) << 8));
                ADDR_PTR_HI:
                    wram_ptr = t_wram_addr'((ptr_wide & 32'h0000_FFFF) | (32'(acc.data) << 16));
                ADDR_FACTOR_A: fac_a = acc.data;
                ADDR_FACTOR_B: begin
                    fac_b    = acc.data;
                    prod_rem = t_word'(16'(fac_a) * 16'(fac_b));
                end
                ADDR_DIVD_LO: dividend = {dividend[15:8], acc.data};
                ADDR_DIVD_HI: dividend = {acc.data, dividend[7:0]};
                ADDR_DIVISOR: begin
                    divisor = acc.data;
                    if (divisor == '0) begin
                        quotient = DIV_ZERO_QUOT;
                        prod_rem = dividend;
                    end else begin
                        quotient = dividend / t_word'(divisor);
                        prod_rem = dividend % t_word'(divisor);
                    end
                end
                default: ;
            endcase
        end else begin
            case (acc.addr)
                ADDR_WRAM_DATA: begin
                    rd = wram_image.exists(int'(wram_ptr)) ? wram_image[int'(wram_ptr)] : '0;
                    wram_ptr = wram_ptr + 1'b1;
                end
                ADDR_QUOT_LO:   rd = quotient[7:0];
                ADDR_QUOT_HI:   rd = quotient[15:8];
                ADDR_PRDREM_LO: rd = prod_rem[7:0];
                ADDR_PRDREM_HI: rd = prod_rem[15:8];
                default: ;
            endcase
        end
        read_bytes_due.push_back(rd);
    endtask

    // Driver: a transfer happens at an edge where start is high and busy is low.
    // Compute the next value of start once per edge so it is never dropped and
    // raised in the same step.
    always @(posedge i_clk) begin : drive_proc
        bit driving;
        if (!i_rst_n) begin
            start     <= 1'b0;
            wait_left = 0;
        end else begin
            driving = start;
            if (start && !busy) begin
                predict_access(access_q[0]);
                void'(access_q.pop_front());
                driving = 1'b0;
                if (access_q.size() != 0) wait_left = access_q[0].gap;
            end
            if (!driving && access_q.size() != 0) begin
                if (wait_left != 0) begin
                    wait_left--;
                end else if (!access_q[0].drain_first || read_bytes_due.size() == 0) begin
                    // Hold the fields steady until the transfer is taken.
                    i_cmd         <= access_q[0].cmd;
                    i_bus_address <= access_q[0].addr;
                    i_write_byte  <= access_q[0].data;
                    driving       = 1'b1;
                end
            end
            start <= driving;
        end
    end

    // Monitor: the strobe cannot be stalled, so every strobed byte is taken and checked.
    always @(posedge i_clk) begin : check_proc
        t_byte due;
        if (i_rst_n && o_strobe) begin
            if (read_bytes_due.size() == 0) begin
                $display("%0t: read byte with nothing outstanding: expected none, actual %02h",
                         $time, o_read_byte);
                fail_count++;
            end else begin
                due = read_bytes_due.pop_front();
                if (o_read_byte !== due) begin
                    $display("%0t: read byte mismatch: expected %02h, actual %02h",
                             $time, due, o_read_byte);
                    fail_count++;
                end
            end
        end
    end

    // Count cycles with neither a transfer nor a result; a stuck block trips the limit.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) idle_cycles <= 0;
        else                              idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("multiply_divide_and_wram_port verification failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned kind;
        int unsigned len;
        int unsigned n;
        t_wram_addr  base;
        t_byte       hi_byte;

        // Directed: RAM clear after reset, pointer top byte masking and wrap,
        // multiply extremes, divide by zero, write-only and read-only registers.
        push_access(CMD_READ,  ADDR_WRAM_DATA, 8'h00);
        push_access(CMD_WRITE, ADDR_PTR_HI,    8'hFF);
        push_access(CMD_WRITE, ADDR_PTR_MID,   8'hFF);
        push_access(CMD_WRITE, ADDR_PTR_LO,    8'hFF);
        push_access(CMD_WRITE, ADDR_WRAM_DATA, 8'hA5);
        push_access(CMD_WRITE, ADDR_WRAM_DATA, 8'h5A);
        push_access(CMD_WRITE, ADDR_PTR_LO,    8'hFF);
        push_access(CMD_WRITE, ADDR_PTR_MID,   8'hFF);
        push_access(CMD_WRITE, ADDR_PTR_HI,    8'h01);
        push_access(CMD_READ,  ADDR_WRAM_DATA, 8'hFF);
        push_access(CMD_READ,  ADDR_WRAM_DATA, 8'h00);
        push_access(CMD_WRITE, ADDR_FACTOR_A,  8'hFF);
        push_access(CMD_WRITE, ADDR_FACTOR_B,  8'hFF);
        push_access(CMD_READ,  ADDR_PRDREM_LO, 8'h00);
        push_access(CMD_READ,  ADDR_PRDREM_HI, 8'h00);
        push_access(CMD_WRITE, ADDR_DIVD_LO,   8'hFF);
        push_access(CMD_WRITE, ADDR_DIVD_HI,   8'hFF);
        push_access(CMD_WRITE, ADDR_DIVISOR,   8'h00);
        push_access(CMD_READ,  ADDR_QUOT_LO,   8'h00);
        push_access(CMD_READ,  ADDR_UNMAPPED,  8'hFF);
        push_access(CMD_WRITE, ADDR_DIVISOR,   8'hFF);
        push_access(CMD_READ,  ADDR_QUOT_HI,   8'h00);
        push_access(CMD_READ,  ADDR_DIVISOR,   8'h00);
        push_access(CMD_WRITE, ADDR_QUOT_LO,   8'h12);
        push_access(CMD_READ,  ADDR_QUOT_LO,   8'h00);

        // Random: mostly well-formed register sequences with random operands,
        // the rest noise over the whole address space.
        n = access_q.size() + RANDOM_ITEMS;
        while (access_q.size() < n) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: begin
                    push_access(CMD_WRITE, ADDR_FACTOR_A, t_byte'($urandom));
                    push_access(CMD_WRITE, ADDR_FACTOR_B, t_byte'($urandom));
                    push_access(CMD_READ,  ADDR_PRDREM_LO, t_byte'($urandom));
                    push_access(CMD_READ,  ADDR_PRDREM_HI, t_byte'($urandom));
                    if ($urandom_range(0, 1) == 0)
                        push_access(CMD_READ, ADDR_QUOT_LO, t_byte'($urandom));
                end
                3, 4, 5: begin
                    push_access(CMD_WRITE, ADDR_DIVD_LO, t_byte'($urandom));
                    push_access(CMD_WRITE, ADDR_DIVD_HI, t_byte'($urandom));
                    push_access(CMD_WRITE, ADDR_DIVISOR,
                                ($urandom_range(0, 7) == 0) ? 8'h00 : t_byte'($urandom));
                    push_access(CMD_READ,  ADDR_QUOT_LO,   t_byte'($urandom));
                    push_access(CMD_READ,  ADDR_QUOT_HI,   t_byte'($urandom));
                    push_access(CMD_READ,  ADDR_PRDREM_LO, t_byte'($urandom));
                    push_access(CMD_READ,  ADDR_PRDREM_HI, t_byte'($urandom));
                end
                6, 7: begin
                    // Write a burst, point back at its start and read it again;
                    // a quarter of the bursts start near the top to cross the wrap.
                    base = t_wram_addr'($urandom);
                    if ($urandom_range(0, 3) == 0)
                        base = t_wram_addr'(WRAM_DEPTH - 1 - $urandom_range(0, 7));
                    len = $urandom_range(1, 8);
                    for (int sweep = 0; sweep < 2; sweep++) begin
                        hi_byte = t_byte'(($urandom << (WRAM_ADDR_BITS - 16)) |
                                          (32'(base) >> 16));
                        push_access(CMD_WRITE, ADDR_PTR_LO,  base[7:0]);
                        push_access(CMD_WRITE, ADDR_PTR_MID, base[15:8]);
                        push_access(CMD_WRITE, ADDR_PTR_HI,  hi_byte);
                        for (int j = 0; j < len; j++)
                            push_access((sweep == 0) ? CMD_WRITE : CMD_READ,
                                        ADDR_WRAM_DATA, t_byte'($urandom));
                    end
                end
                default: begin
                    repeat ($urandom_range(1, 3)) begin
                        case ($urandom_range(0, 2))
                            0: push_access(logic'($urandom), t_addr16'($urandom),
                                           t_byte'($urandom));
                            1: push_access(logic'($urandom),
                                           t_addr16'(ADDR_WRAM_DATA + $urandom_range(0, 7)),
                                           t_byte'($urandom));
                            default: push_access(logic'($urandom),
                                                 t_addr16'(ADDR_FACTOR_A - 2 +
                                                           $urandom_range(0, 31)),
                                                 t_byte'($urandom));
                        endcase
                    end
                end
            endcase
        end

        // Single reset at the start; the block then clears its RAM with busy high.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every access to transfer, then for every result, then a tail.
        while (access_q.size() != 0 || start) @(posedge i_clk);
        while (read_bytes_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("multiply_divide_and_wram_port verification clean");
        end else begin
            $display("multiply_divide_and_wram_port verification failed");
        end
        $finish;
    end

endmodule
